// ----- rtl/ilp_pkg.sv -----
// Package for the integer literal parser: beat and token types, radix,
// status and compare codes, and the table of the largest decimal literal.
// Depends on nothing; every other file of the block imports it.
package ilp_pkg;

    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [1:0] RADIX_DEC = 2'd0;
    localparam logic [1:0] RADIX_HEX = 2'd1;
    localparam logic [1:0] RADIX_OCT = 2'd2;
    localparam logic [1:0] RADIX_BIN = 2'd3;

    localparam logic [1:0] CMP_EQ = 2'd0;
    localparam logic [1:0] CMP_LT = 2'd1;
    localparam logic [1:0] CMP_GT = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_LONG = 2'd1;
    localparam logic [1:0] ST_BAD  = 2'd2;

    localparam logic [6:0] DEC_MAX_DIGITS = 7'd20;
    localparam logic [6:0] HEX_MAX_DIGITS = 7'd16;
    localparam logic [6:0] OCT_MAX_DIGITS = 7'd22;
    localparam logic [6:0] BIN_MAX_DIGITS = 7'd64;
    localparam logic [6:0] COUNT_SAT      = 7'd127;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } item_t;

    typedef struct packed {
        logic [63:0] value;
        logic [1:0]  status;
    } result_t;

    typedef struct packed {
        logic       take;
        logic       ok;
        logic [3:0] dval;
        logic [1:0] radix;
        logic [7:0] code;
        logic       last;
    } tok_t;

    function automatic logic [7:0] max_digit(input logic [4:0] idx);
        logic [7:0] c;
        unique case (idx)
            5'd0:  c = "1";
            5'd1:  c = "8";
            5'd2:  c = "4";
            5'd3:  c = "4";
            5'd4:  c = "6";
            5'd5:  c = "7";
            5'd6:  c = "4";
            5'd7:  c = "4";
            5'd8:  c = "0";
            5'd9:  c = "7";
            5'd10: c = "3";
            5'd11: c = "7";
            5'd12: c = "0";
            5'd13: c = "9";
            5'd14: c = "5";
            5'd15: c = "5";
            5'd16: c = "1";
            5'd17: c = "6";
            5'd18: c = "1";
            5'd19: c = "5";
            default: c = "0";
        endcase
        return c;
    endfunction

endpackage

// ----- rtl/ilp_front.sv -----
// Front part: tracks the leading phase and the radix prefix, and turns each
// accepted character beat into a classified token for the queue.
// Depends on ilp_pkg.
module ilp_front
    import ilp_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  item_t item,
    input  logic  accept,
    output tok_t  tok
);

    logic [1:0] radix_reg, radix_next;
    logic       leading_reg, leading_next;
    logic [7:0] c;
    logic       take;
    logic       ok;
    logic [3:0] dval;

    assign c = item.char_code;

    always_comb
    begin
        radix_next   = radix_reg;
        leading_next = leading_reg;
        take         = 1'b1;
        if (leading_reg)
        begin
            priority if (c == "0")
            begin
                take = 1'b0;
            end
            else if (radix_reg == RADIX_DEC && (c == "x" || c == "X"))
            begin
                radix_next = RADIX_HEX;
                take       = 1'b0;
            end
            else if (radix_reg == RADIX_DEC && (c == "o" || c == "O"))
            begin
                radix_next = RADIX_OCT;
                take       = 1'b0;
            end
            else if (radix_reg == RADIX_DEC && (c == "b" || c == "B"))
            begin
                radix_next = RADIX_BIN;
                take       = 1'b0;
            end
            else
            begin
                leading_next = 1'b0;
            end
        end
    end

    always_comb
    begin
        logic [7:0] d;
        d  = 8'd0;
        ok = 1'b0;
        unique case (radix_next)
            RADIX_DEC:
            begin
                if (c >= "0" && c <= "9")
                begin
                    d  = c - 8'h30;
                    ok = 1'b1;
                end
            end
            RADIX_HEX:
            begin
                priority if (c >= "0" && c <= "9")
                begin
                    d  = c - 8'h30;
                    ok = 1'b1;
                end
                else if (c >= "a" && c <= "f")
                begin
                    d  = c - 8'h57;
                    ok = 1'b1;
                end
                else if (c >= "A" && c <= "F")
                begin
                    d  = c - 8'h37;
                    ok = 1'b1;
                end
                else
                begin
                    d  = 8'd0;
                    ok = 1'b0;
                end
            end
            RADIX_OCT:
            begin
                if (c >= "0" && c <= "7")
                begin
                    d  = c - 8'h30;
                    ok = 1'b1;
                end
            end
            default:
            begin
                if (c == "0" || c == "1")
                begin
                    d  = c - 8'h30;
                    ok = 1'b1;
                end
            end
        endcase
        dval = d[3:0];
    end

    assign tok = '{take: take, ok: ok, dval: dval, radix: radix_next,
                   code: c, last: item.last_char};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg   <= RADIX_DEC;
            leading_reg <= 1'b1;
        end
        else if (accept)
        begin
            if (item.last_char)
            begin
                radix_reg   <= RADIX_DEC;
                leading_reg <= 1'b1;
            end
            else
            begin
                radix_reg   <= radix_next;
                leading_reg <= leading_next;
            end
        end
    end

endmodule

// ----- rtl/ilp_queue.sv -----
// Short token queue between the front and the back part, built from
// flip-flops with a read and a write pointer. Depends on ilp_pkg.
module ilp_queue
    import ilp_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  tok_t wr_tok,
    input  logic pop,
    output tok_t rd_tok,
    output logic full,
    output logic empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    tok_t          mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;

    assign rd_tok = mem_reg[rd_ptr_reg];
    assign full   = (count_reg == CNT_FULL);
    assign empty  = (count_reg == '0);

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_tok;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ----- rtl/ilp_back.sv -----
// Back part: accumulates digits, tracks the length limits and the bad
// character flag, and holds the result beat in an output register.
// Depends on ilp_pkg.
module ilp_back
    import ilp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  tok_t    tok,
    input  logic    tok_valid,
    output logic    pop,
    output result_t result,
    output logic    result_valid,
    input  logic    result_stall
);

    logic [63:0] accum_reg, accum_next;
    logic [6:0]  count_reg, count_next;
    logic        bad_reg, bad_next;
    logic [1:0]  cmp_reg, cmp_next;
    logic        fdh_reg, fdh_next;
    result_t     result_reg, result_next;
    logic        rvalid_reg, rvalid_next;

    assign pop = tok_valid && (!tok.last || !rvalid_reg || !result_stall);

    always_comb
    begin
        logic [63:0] a;
        logic [7:0]  ref_c;
        logic        too_long;
        logic [1:0]  st;

        accum_next  = accum_reg;
        count_next  = count_reg;
        bad_next    = bad_reg;
        cmp_next    = cmp_reg;
        fdh_next    = fdh_reg;
        result_next = result_reg;
        rvalid_next = rvalid_reg && result_stall;
        a           = accum_reg;
        ref_c       = max_digit(count_reg[4:0]);
        too_long    = 1'b0;
        st          = ST_OK;

        if (pop && tok.take)
        begin
            if (count_reg == '0)
            begin
                fdh_next = (tok.code >= "2");
            end
            if (count_reg < DEC_MAX_DIGITS && cmp_reg == CMP_EQ)
            begin
                if (tok.code > ref_c)
                begin
                    cmp_next = CMP_GT;
                end
                else if (tok.code < ref_c)
                begin
                    cmp_next = CMP_LT;
                end
            end
            if (tok.ok)
            begin
                unique case (tok.radix)
                    RADIX_DEC: accum_next = (a << 3) + (a << 1) + {60'd0, tok.dval};
                    RADIX_HEX: accum_next = {a[59:0], tok.dval};
                    RADIX_OCT: accum_next = {a[60:0], tok.dval[2:0]};
                    default:   accum_next = {a[62:0], tok.dval[0]};
                endcase
            end
            else
            begin
                bad_next = 1'b1;
            end
            if (count_reg < COUNT_SAT)
            begin
                count_next = count_reg + 7'd1;
            end
        end

        if (pop && tok.last)
        begin
            unique case (tok.radix)
                RADIX_DEC: too_long = (count_next > DEC_MAX_DIGITS)
                                   || (count_next == DEC_MAX_DIGITS && cmp_next == CMP_GT);
                RADIX_HEX: too_long = (count_next > HEX_MAX_DIGITS);
                RADIX_OCT: too_long = (count_next > OCT_MAX_DIGITS)
                                   || (count_next == OCT_MAX_DIGITS && fdh_next);
                default:   too_long = (count_next > BIN_MAX_DIGITS);
            endcase
            priority if (count_next == '0)
            begin
                st = ST_OK;
            end
            else if (too_long)
            begin
                st = ST_LONG;
            end
            else if (bad_next)
            begin
                st = ST_BAD;
            end
            else
            begin
                st = ST_OK;
            end
            result_next.status = st;
            result_next.value  = (st == ST_OK && count_next != '0) ? accum_next : 64'd0;
            rvalid_next        = 1'b1;
            accum_next         = '0;
            count_next         = '0;
            bad_next           = 1'b0;
            cmp_next           = CMP_EQ;
            fdh_next           = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accum_reg  <= '0;
            count_reg  <= '0;
            bad_reg    <= 1'b0;
            cmp_reg    <= CMP_EQ;
            fdh_reg    <= 1'b0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            accum_reg  <= accum_next;
            count_reg  <= count_next;
            bad_reg    <= bad_next;
            cmp_reg    <= cmp_next;
            fdh_reg    <= fdh_next;
            rvalid_reg <= rvalid_next;
        end
    end

    assign result       = result_reg;
    assign result_valid = rvalid_reg;

endmodule

// ----- rtl/integer_literal_parser.sv -----
// Integer literal parser: one character beat per cycle in while item_stall is
// low, one result beat after the beat marked last, offered from the back
// part's output register once the last character has passed the token queue.
// The front, queue and back part each take one beat per cycle when unstalled.
// Reset clears the leading phase, the radix, the queue and the accumulator.
// Depends on ilp_pkg, ilp_front, ilp_queue and ilp_back.
module integer_literal_parser
    import ilp_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_stall,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    tok_t front_tok;
    tok_t back_tok;
    logic accept;
    logic q_full;
    logic q_empty;
    logic q_pop;

    assign item_stall = q_full;
    assign accept     = item_valid && !q_full;

    ilp_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .accept (accept),
        .tok    (front_tok)
    );

    ilp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (accept),
        .wr_tok (front_tok),
        .pop    (q_pop),
        .rd_tok (back_tok),
        .full   (q_full),
        .empty  (q_empty)
    );

    ilp_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .tok          (back_tok),
        .tok_valid    (!q_empty),
        .pop          (q_pop),
        .result       (result),
        .result_valid (result_valid),
        .result_stall (result_stall)
    );

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.status == ST_OK || result.status == ST_LONG
                          || result.status == ST_BAD))
        else $error("result status code out of range");

    a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.status != ST_OK) |-> (result.value == 64'd0))
        else $error("nonzero value with error status");

    a_queue_flags: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_full && q_empty))
        else $error("queue full and empty at once");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("queue popped while empty");

endmodule
